/* src/kmer_frequency_counter_assert.svh */
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef KMER_FREQUENCY_COUNTER_ASSERT_SVH
`define KMER_FREQUENCY_COUNTER_ASSERT_SVH

// Same-cycle implication.
`define KFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kfc assertion failed");

// Next-cycle implication.
`define KFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kfc assertion failed");

`endif

/* src/kfc_pkg.sv */
package kfc_pkg;

  localparam int unsigned KMER_LENGTH = 8;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned INDEX_W     = 2 * KMER_LENGTH;
  localparam int unsigned DIST_W      = INDEX_W + 1;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = {COUNT_WIDTH{1'b1}};
  localparam logic [31:0]            TOTAL_MAX    = 32'hFFFF_FFFF;
  localparam logic [INDEX_W-1:0]     INDEX_LAST   = {INDEX_W{1'b1}};
  localparam logic [7:0]             READ_LEN_RST = 8'd150;
  localparam logic [7:0]             KMER_LEN_B   = 8'(KMER_LENGTH);

  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UC = 8'h43;
  localparam logic [7:0] CHAR_UG = 8'h47;
  localparam logic [7:0] CHAR_UT = 8'h54;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LC = 8'h63;
  localparam logic [7:0] CHAR_LG = 8'h67;
  localparam logic [7:0] CHAR_LT = 8'h74;

  typedef enum logic [1:0] {
    BASE_A,
    BASE_C,
    BASE_G,
    BASE_T
  } base_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_COUNT,
    OP_QUERY
  } kop_e;

  typedef struct packed {
    kop_e               op;
    logic [INDEX_W-1:0] idx;
    logic               bad;
  } kfc_entry_t;

  function automatic logic base_ok(input logic [7:0] ch);
    logic ok;
    case (ch) inside
      CHAR_UA, CHAR_LA, CHAR_UC, CHAR_LC,
      CHAR_UG, CHAR_LG, CHAR_UT, CHAR_LT: ok = 1'b1;
      default:                            ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic base_e base_code(input logic [7:0] ch);
    base_e code;
    case (ch) inside
      CHAR_UC, CHAR_LC: code = BASE_C;
      CHAR_UG, CHAR_LG: code = BASE_G;
      CHAR_UT, CHAR_LT: code = BASE_T;
      default:          code = BASE_A;
    endcase
    return code;
  endfunction

endpackage

/* src/kfc_req_if.sv */
interface kfc_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  base_char;
  logic        end_of_read;
  logic [15:0] query_index;

  modport source (output valid, kind, base_char, end_of_read, query_index, input ready);
  modport sink   (input valid, kind, base_char, end_of_read, query_index, output ready);
endinterface

/* src/kfc_rsp_if.sv */
interface kfc_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] kmer_index;
  logic [31:0] kmer_count;
  logic        counted;
  logic        bad_base;
  logic [16:0] distinct_kmers;
  logic [31:0] total_kmers;

  modport source (output valid, kmer_index, kmer_count, counted, bad_base,
                  distinct_kmers, total_kmers, input ready);
  modport sink   (input valid, kmer_index, kmer_count, counted, bad_base,
                  distinct_kmers, total_kmers, output ready);
endinterface

/* src/kfc_front.sv */
module kfc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  kfc_req_if.sink             req_i,
  input  logic                space_i,
  output logic                push_o,
  output kfc_pkg::kfc_entry_t entry_o
);
  import kfc_pkg::*;

  logic [INDEX_W-1:0] win_q, win_d;
  logic [7:0]         bir_q, bir_d;
  logic [7:0]         rlen_q;
  logic [7:0]         bir_inc;
  logic [INDEX_W-1:0] win_next;
  logic               fire;

  assign req_i.ready = space_i;
  assign fire        = req_i.valid && space_i;
  assign push_o      = fire;

  assign bir_inc  = bir_q + 8'd1;
  assign win_next = INDEX_W'({win_q, base_code(req_i.base_char)});

  always_comb begin
    win_d         = win_q;
    bir_d         = bir_q;
    entry_o.op    = OP_NONE;
    entry_o.idx   = '0;
    entry_o.bad   = 1'b0;
    if (req_i.kind) begin
      entry_o.op  = OP_QUERY;
      entry_o.idx = INDEX_W'(req_i.query_index);
    end else begin
      if (bir_q < rlen_q) begin
        if (!base_ok(req_i.base_char)) begin
          entry_o.bad = 1'b1;
          win_d       = '0;
          bir_d       = '0;
        end else begin
          win_d = win_next;
          bir_d = bir_inc;
          if (bir_inc >= KMER_LEN_B) begin
            entry_o.op  = OP_COUNT;
            entry_o.idx = win_next;
          end
        end
      end
      if (req_i.end_of_read) begin
        win_d = '0;
        bir_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      bir_q  <= '0;
      rlen_q <= READ_LEN_RST;
    end else begin
      if (fire) begin
        win_q <= win_d;
        bir_q <= bir_d;
      end
      if (cfg_we_i) begin
        rlen_q <= cfg_wdata_i;
      end
    end
  end

endmodule

/* src/kfc_fifo.sv */
module kfc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  kfc_pkg::kfc_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output kfc_pkg::kfc_entry_t head_o
);
  import kfc_pkg::*;

  kfc_entry_t        slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + QCNT_W'(1);
    if (pop_i && !push_i) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
      if (pop_i)  rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule

/* src/kfc_back.sv */
module kfc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kfc_pkg::kfc_entry_t head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                clearing_o,
  kfc_rsp_if.source           rsp_o
);
  import kfc_pkg::*;

  logic [COUNT_WIDTH-1:0] mem [2**INDEX_W];
  logic [COUNT_WIDTH-1:0] rdata_q;

  logic               clr_q;
  logic [INDEX_W-1:0] clr_addr_q;

  logic       s1_vld_q;
  kfc_entry_t s1_q;
  logic       s1_adv;

  // last table write, forwarded on an index match
  logic                   wr_vld_q;
  logic [INDEX_W-1:0]     wr_idx_q;
  logic [COUNT_WIDTH-1:0] wr_val_q;

  logic [DIST_W-1:0] dist_q, dist_d;
  logic [31:0]       total_q, total_d;

  logic [COUNT_WIDTH-1:0] cur_cnt, new_cnt;
  logic                   do_count;

  logic                   mem_we;
  logic [INDEX_W-1:0]     mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  logic        out_vld_q, out_vld_d;
  logic [15:0] out_idx_q, out_idx_d;
  logic [31:0] out_cnt_q, out_cnt_d;
  logic        out_counted_q, out_counted_d;
  logic        out_bad_q, out_bad_d;
  logic [16:0] out_dist_q;
  logic [31:0] out_total_q;

  assign clearing_o = clr_q;
  assign s1_adv     = s1_vld_q && (!out_vld_q || rsp_o.ready);
  assign pop_o      = !empty_i && !clr_q && (!s1_vld_q || s1_adv);

  assign cur_cnt  = (wr_vld_q && (wr_idx_q == s1_q.idx)) ? wr_val_q : rdata_q;
  assign new_cnt  = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);
  assign do_count = s1_adv && (s1_q.op == OP_COUNT);

  assign mem_we    = clr_q || do_count;
  assign mem_waddr = clr_q ? clr_addr_q : s1_q.idx;
  assign mem_wdata = clr_q ? '0 : new_cnt;

  always_comb begin
    dist_d  = dist_q;
    total_d = total_q;
    if (do_count) begin
      if (cur_cnt == '0)       dist_d  = dist_q + DIST_W'(1);
      if (total_q != TOTAL_MAX) total_d = total_q + 32'd1;
    end
  end

  always_comb begin
    out_idx_d     = '0;
    out_cnt_d     = '0;
    out_counted_d = 1'b0;
    out_bad_d     = s1_q.bad;
    case (s1_q.op)
      OP_COUNT: begin
        out_idx_d     = 16'(s1_q.idx);
        out_cnt_d     = 32'(new_cnt);
        out_counted_d = 1'b1;
      end
      OP_QUERY: begin
        out_idx_d = 16'(s1_q.idx);
        out_cnt_d = 32'(cur_cnt);
      end
      default: ;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (s1_adv)           out_vld_d = 1'b1;
    else if (rsp_o.ready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (pop_o)  rdata_q <= mem[head_i.idx];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) s1_q <= head_i;
    if (do_count) begin
      wr_idx_q <= s1_q.idx;
      wr_val_q <= new_cnt;
    end
    if (s1_adv) begin
      out_idx_q     <= out_idx_d;
      out_cnt_q     <= out_cnt_d;
      out_counted_q <= out_counted_d;
      out_bad_q     <= out_bad_d;
      out_dist_q    <= 17'(dist_d);
      out_total_q   <= total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      s1_vld_q   <= 1'b0;
      wr_vld_q   <= 1'b0;
      dist_q     <= '0;
      total_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + INDEX_W'(1);
        if (clr_addr_q == INDEX_LAST) clr_q <= 1'b0;
      end
      if (pop_o)       s1_vld_q <= 1'b1;
      else if (s1_adv) s1_vld_q <= 1'b0;
      if (do_count)    wr_vld_q <= 1'b1;
      dist_q    <= dist_d;
      total_q   <= total_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.kmer_index     = out_idx_q;
  assign rsp_o.kmer_count     = out_cnt_q;
  assign rsp_o.counted        = out_counted_q;
  assign rsp_o.bad_base       = out_bad_q;
  assign rsp_o.distinct_kmers = out_dist_q;
  assign rsp_o.total_kmers    = out_total_q;

endmodule

/* src/kmer_frequency_counter.sv */
// A request passes the queue, stage 1 (table read) and the output register.
// Throughput: one request per cycle while the response is taken; the table
// read-modify-write spans the queue pop and one stage, and the last table write is
// forwarded on a repeated k-mer. Reset: control state clears at once; then a
// clearing pass zeroes all 65536 table entries, one a cycle; no request is taken.
module kmer_frequency_counter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  kfc_req_if.sink    req_i,
  kfc_rsp_if.source  rsp_o
);
  import kfc_pkg::*;

  logic       push;
  kfc_entry_t entry;
  logic       full;
  logic       pop;
  logic       empty;
  kfc_entry_t head;
  logic       clearing;
  logic       space;

  assign space = !full && !clearing;

  kfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .space_i     (space),
    .push_o      (push),
    .entry_o     (entry)
  );

  kfc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  kfc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .clearing_o (clearing),
    .rsp_o      (rsp_o)
  );

`include "kmer_frequency_counter_assert.svh"

  `KFC_ASSERT_NOW(a_no_accept_while_clearing, clearing, !req_i.ready)
  `KFC_ASSERT_NOW(a_counted_nonzero, rsp_o.valid && rsp_o.counted, rsp_o.kmer_count != 32'd0)
  `KFC_ASSERT_NOW(a_counted_not_bad, rsp_o.valid && rsp_o.bad_base, !rsp_o.counted)
  `KFC_ASSERT_NEXT(a_clear_ends_once, !clearing, !clearing)

endmodule
